// ===== rtl/mart_pkg.sv =====
// ----------------------------------------------------------------------------
// mart_pkg
// Shared types and constants of the multicast ACK and retransmit tracker.
// ----------------------------------------------------------------------------
package mart_pkg;

    // Default sizes
    localparam int PENDING_SLOTS_DEF     = 8;
    localparam int MEMBERS_PER_GROUP_DEF = 8;
    localparam int GROUP_SLOTS_DEF       = 4;

    // Result limit per item
    localparam int OUT_LIMIT = 64;

    // Register reset values
    localparam logic [15:0] TIMEOUT_RST = 16'd10;
    localparam logic [3:0]  RETRIES_RST = 4'd3;

    // Register indexes
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_RETRIES = 1'b1;

    // Item kinds
    localparam logic [2:0] KIND_JOIN   = 3'd0;
    localparam logic [2:0] KIND_LEAVE  = 3'd1;
    localparam logic [2:0] KIND_NOTIFY = 3'd2;
    localparam logic [2:0] KIND_ACK    = 3'd3;
    localparam logic [2:0] KIND_TICK   = 3'd4;

    // Event codes
    localparam logic [2:0] EV_SEND   = 3'd0;
    localparam logic [2:0] EV_RETX   = 3'd1;
    localparam logic [2:0] EV_EXPIRE = 3'd2;
    localparam logic [2:0] EV_DROP   = 3'd3;
    localparam logic [2:0] EV_FULL   = 3'd4;
    localparam logic [2:0] EV_DONE   = 3'd5;

    // Controller to datapath commands
    typedef struct packed {
        logic       ld_item;
        logic       gi_clr;
        logic       gi_inc;
        logic       g_take;
        logic       g_add;
        logic       grp_load;
        logic       mj_clr;
        logic       mj_inc;
        logic       seq_take;
        logic       mem_rd;
        logic       rd_last;
        logic       wr_join;
        logic       wr_leave;
        logic       si_clr;
        logic       si_inc;
        logic       slot_init;
        logic       slot_load;
        logic       slot_free;
        logic       ack_set;
        logic       tick_dec;
        logic       retry_inc;
        logic       cd_reload;
        logic       lost_clr;
        logic       lost_acc;
        logic       emit;
        logic [2:0] ev;
        logic       flush;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] kind;
        logic       gi_lt_gu;
        logic       g_match;
        logic       gu_full;
        logic       mj_lt_cnt;
        logic       mj_lt_lim;
        logic       addr_match;
        logic       cnt_full;
        logic       si_last;
        logic       slot_act;
        logic       seq_match;
        logic       all_acked;
        logic       cd_hits;
        logic       retry_limit;
        logic       ack_bit;
        logic       emit_ok;
        logic       hold_valid;
        logic       out_free;
    } sts_t;

endpackage

// ===== rtl/multicast_ack_retransmit_tracker.sv =====
// ----------------------------------------------------------------------------
// multicast_ack_retransmit_tracker
// Tracks multicast groups, pending deliveries with ACK bitmaps, and
// retransmit or expiry on timer ticks.
// ----------------------------------------------------------------------------
//  Channel  | Handshake            | Payload
//  ---------+----------------------+----------------------------------------
//  in       | in_valid / in_stall  | kind, group_no, sub_addr, ack_seq
//  out      | out_valid / out_stall| event_code, seq, out_group, dest_addr,
//           |                      | lost_count, attempt, last
//  cfg      | cfg_we               | cfg_index, cfg_data
//
//  One item at a time; in_stall is high until its last result is in the
//  output register. Groups and slots are searched one after another, and
//  each member visit goes through a registered member RAM read.
//  A tick visits every slot, with a member walk on a retransmit round
//  and a lost count walk over the members before an expiry.
//  Reset clears the group count, member counts, slot flags and sequence.
//  out_stall holds the walk only when a new result has nowhere to go.
// ----------------------------------------------------------------------------
module multicast_ack_retransmit_tracker #(
    parameter int PENDING_SLOTS     = mart_pkg::PENDING_SLOTS_DEF,
    parameter int MEMBERS_PER_GROUP = mart_pkg::MEMBERS_PER_GROUP_DEF,
    parameter int GROUP_SLOTS       = mart_pkg::GROUP_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [15:0] group_no,
    input  logic [47:0] sub_addr,
    input  logic [15:0] ack_seq,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_code,
    output logic [15:0] seq,
    output logic [15:0] out_group,
    output logic [47:0] dest_addr,
    output logic [3:0]  lost_count,
    output logic [3:0]  attempt,
    output logic        last,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    mart_pkg::cmd_t cmd;
    mart_pkg::sts_t sts;
    logic           idle;

    assign in_stall = !idle;

    // Sequencer
    mart_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_kind  (kind),
        .sts      (sts),
        .cmd      (cmd),
        .idle     (idle)
    );

    // Tables and result path
    mart_dp #(
        .PENDING_SLOTS     (PENDING_SLOTS),
        .MEMBERS_PER_GROUP (MEMBERS_PER_GROUP),
        .GROUP_SLOTS       (GROUP_SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .kind       (kind),
        .group_no   (group_no),
        .sub_addr   (sub_addr),
        .ack_seq    (ack_seq),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_code (event_code),
        .seq        (seq),
        .out_group  (out_group),
        .dest_addr  (dest_addr),
        .lost_count (lost_count),
        .attempt    (attempt),
        .last       (last)
    );

endmodule

// ===== rtl/mart_ctrl.sv =====
// ----------------------------------------------------------------------------
// mart_ctrl
// Sequencer: walks groups, members and pending slots for each item.
// ----------------------------------------------------------------------------
module mart_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [2:0]       in_kind,
    input  mart_pkg::sts_t   sts,
    output mart_pkg::cmd_t   cmd,
    output logic             idle
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_GSRCH = 4'd1;
    localparam logic [3:0] S_GLOAD = 4'd2;
    localparam logic [3:0] S_MRD   = 4'd3;
    localparam logic [3:0] S_MCHK  = 4'd4;
    localparam logic [3:0] S_LWR   = 4'd5;
    localparam logic [3:0] S_SFREE = 4'd6;
    localparam logic [3:0] S_ASRCH = 4'd7;
    localparam logic [3:0] S_ADONE = 4'd8;
    localparam logic [3:0] S_TSLOT = 4'd9;
    localparam logic [3:0] S_TLOST = 4'd10;
    localparam logic [3:0] S_TEXP  = 4'd11;
    localparam logic [3:0] S_TRD   = 4'd12;
    localparam logic [3:0] S_TNEXT = 4'd13;
    localparam logic [3:0] S_FIN   = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign idle = (state_reg == S_IDLE);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.ld_item = 1'b1;
                    cmd.gi_clr  = 1'b1;
                    cmd.si_clr  = 1'b1;
                    priority if (in_kind == mart_pkg::KIND_JOIN ||
                                 in_kind == mart_pkg::KIND_LEAVE ||
                                 in_kind == mart_pkg::KIND_NOTIFY)
                        state_next = S_GSRCH;
                    else if (in_kind == mart_pkg::KIND_ACK)
                        state_next = S_ASRCH;
                    else if (in_kind == mart_pkg::KIND_TICK)
                        state_next = S_TSLOT;
                    else
                        state_next = S_FIN;
                end
            end
            S_GSRCH:
            begin
                priority if (sts.gi_lt_gu)
                begin
                    if (sts.g_match)
                    begin
                        cmd.g_take = 1'b1;
                        state_next = S_GLOAD;
                    end
                    else
                    begin
                        cmd.gi_inc = 1'b1;
                    end
                end
                else if (sts.kind == mart_pkg::KIND_NOTIFY)
                begin
                    state_next = S_FIN;
                end
                else if (!sts.gu_full)
                begin
                    cmd.g_add  = 1'b1;
                    state_next = S_GLOAD;
                end
                else if (sts.kind == mart_pkg::KIND_JOIN)
                begin
                    if (sts.emit_ok)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.ev     = mart_pkg::EV_FULL;
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_GLOAD:
            begin
                cmd.grp_load = 1'b1;
                cmd.mj_clr   = 1'b1;
                cmd.seq_take = (sts.kind == mart_pkg::KIND_NOTIFY);
                state_next   = S_MRD;
            end
            S_MRD:
            begin
                priority if (sts.mj_lt_cnt)
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_MCHK;
                end
                else if (sts.kind == mart_pkg::KIND_JOIN)
                begin
                    if (!sts.cnt_full)
                    begin
                        cmd.wr_join = 1'b1;
                        state_next  = S_FIN;
                    end
                    else if (sts.emit_ok)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.ev     = mart_pkg::EV_FULL;
                        state_next = S_FIN;
                    end
                end
                else if (sts.kind == mart_pkg::KIND_NOTIFY)
                begin
                    cmd.si_clr = 1'b1;
                    state_next = S_SFREE;
                end
                else if (sts.kind == mart_pkg::KIND_ACK)
                begin
                    state_next = S_ADONE;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_MCHK:
            begin
                priority if (sts.kind == mart_pkg::KIND_NOTIFY)
                begin
                    if (sts.emit_ok)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.ev     = mart_pkg::EV_SEND;
                        cmd.mj_inc = 1'b1;
                        state_next = S_MRD;
                    end
                end
                else if (sts.kind == mart_pkg::KIND_TICK)
                begin
                    if (sts.ack_bit)
                    begin
                        cmd.mj_inc = 1'b1;
                        state_next = S_TRD;
                    end
                    else if (sts.emit_ok)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.ev     = mart_pkg::EV_RETX;
                        cmd.mj_inc = 1'b1;
                        state_next = S_TRD;
                    end
                end
                else if (!sts.addr_match)
                begin
                    cmd.mj_inc = 1'b1;
                    state_next = S_MRD;
                end
                else if (sts.kind == mart_pkg::KIND_LEAVE)
                begin
                    cmd.rd_last = 1'b1;
                    state_next  = S_LWR;
                end
                else if (sts.kind == mart_pkg::KIND_ACK)
                begin
                    cmd.ack_set = 1'b1;
                    state_next  = S_ADONE;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_LWR:
            begin
                cmd.wr_leave = 1'b1;
                state_next   = S_FIN;
            end
            S_SFREE:
            begin
                priority if (!sts.slot_act)
                begin
                    cmd.slot_init = 1'b1;
                    state_next    = S_FIN;
                end
                else if (!sts.si_last)
                begin
                    cmd.si_inc = 1'b1;
                end
                else if (sts.emit_ok)
                begin
                    cmd.emit   = 1'b1;
                    cmd.ev     = mart_pkg::EV_DROP;
                    state_next = S_FIN;
                end
            end
            S_ASRCH:
            begin
                priority if (sts.slot_act && sts.seq_match)
                begin
                    cmd.slot_load = 1'b1;
                    cmd.mj_clr    = 1'b1;
                    state_next    = S_MRD;
                end
                else if (sts.si_last)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.si_inc = 1'b1;
                end
            end
            S_ADONE:
            begin
                if (!sts.all_acked)
                begin
                    state_next = S_FIN;
                end
                else if (sts.emit_ok)
                begin
                    cmd.emit      = 1'b1;
                    cmd.ev        = mart_pkg::EV_DONE;
                    cmd.slot_free = 1'b1;
                    state_next    = S_FIN;
                end
            end
            S_TSLOT:
            begin
                state_next = S_TNEXT;
                if (sts.slot_act)
                begin
                    cmd.tick_dec = 1'b1;
                    if (sts.cd_hits)
                    begin
                        cmd.slot_load = 1'b1;
                        cmd.mj_clr    = 1'b1;
                        if (sts.retry_limit)
                        begin
                            cmd.lost_clr = 1'b1;
                            state_next   = S_TLOST;
                        end
                        else
                        begin
                            cmd.retry_inc = 1'b1;
                            state_next    = S_TRD;
                        end
                    end
                end
            end
            S_TLOST:
            begin
                if (sts.mj_lt_cnt)
                begin
                    cmd.lost_acc = 1'b1;
                    cmd.mj_inc   = 1'b1;
                end
                else
                begin
                    state_next = S_TEXP;
                end
            end
            S_TEXP:
            begin
                if (sts.emit_ok)
                begin
                    cmd.emit      = 1'b1;
                    cmd.ev        = mart_pkg::EV_EXPIRE;
                    cmd.slot_free = 1'b1;
                    state_next    = S_TNEXT;
                end
            end
            S_TRD:
            begin
                if (sts.mj_lt_lim)
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_MCHK;
                end
                else
                begin
                    cmd.cd_reload = 1'b1;
                    state_next    = S_TNEXT;
                end
            end
            S_TNEXT:
            begin
                if (sts.si_last)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.si_inc = 1'b1;
                    state_next = S_TSLOT;
                end
            end
            S_FIN:
            begin
                if (!sts.hold_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/mart_dp.sv =====
// ----------------------------------------------------------------------------
// mart_dp
// Datapath: group table, member RAM, pending slots, result hold and output.
// ----------------------------------------------------------------------------
module mart_dp #(
    parameter int PENDING_SLOTS     = mart_pkg::PENDING_SLOTS_DEF,
    parameter int MEMBERS_PER_GROUP = mart_pkg::MEMBERS_PER_GROUP_DEF,
    parameter int GROUP_SLOTS       = mart_pkg::GROUP_SLOTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  mart_pkg::cmd_t   cmd,
    output mart_pkg::sts_t   sts,
    input  logic [2:0]       kind,
    input  logic [15:0]      group_no,
    input  logic [47:0]      sub_addr,
    input  logic [15:0]      ack_seq,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [15:0]      cfg_data,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [2:0]       event_code,
    output logic [15:0]      seq,
    output logic [15:0]      out_group,
    output logic [47:0]      dest_addr,
    output logic [3:0]       lost_count,
    output logic [3:0]       attempt,
    output logic             last
);

    localparam int GW    = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
    localparam int GCW   = $clog2(GROUP_SLOTS + 1);
    localparam int MW    = (MEMBERS_PER_GROUP > 1) ? $clog2(MEMBERS_PER_GROUP) : 1;
    localparam int MCW   = $clog2(MEMBERS_PER_GROUP + 1);
    localparam int SW    = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
    localparam int DEPTH = GROUP_SLOTS * MEMBERS_PER_GROUP;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = (MCW > 4) ? MCW : 4;
    localparam int RCW   = $clog2(mart_pkg::OUT_LIMIT + 1);

    // Configuration
    logic [15:0] tmo_reg;
    logic [3:0]  maxr_reg;

    // Current item
    logic [2:0]  kind_reg;
    logic [15:0] gid_reg;
    logic [47:0] addr_reg;
    logic [15:0] aseq_reg;

    // Walk counters and working values
    logic [GCW-1:0] gi_reg;
    logic [GW-1:0]  g_reg;
    logic [MCW-1:0] mj_reg;
    logic [MW-1:0]  jm_reg;
    logic [MCW-1:0] cnt_reg;
    logic [SW-1:0]  si_reg;
    logic [15:0]    s_reg;
    logic [LW-1:0]  lost_reg;
    logic [RCW-1:0] res_cnt_reg;

    // Group table
    logic [15:0]    grp_num_reg [GROUP_SLOTS];
    logic [GCW-1:0] gu_reg;
    logic [MCW-1:0] mcnt_reg [GROUP_SLOTS];
    logic [15:0]    next_seq_reg;

    // Member RAM
    logic [47:0]    member_ram [DEPTH];
    logic [47:0]    rdata_reg;

    // Pending slots
    logic                         slot_act_reg  [PENDING_SLOTS];
    logic [15:0]                  slot_seq_reg  [PENDING_SLOTS];
    logic [GW-1:0]                slot_grp_reg  [PENDING_SLOTS];
    logic [MCW-1:0]               slot_mem_reg  [PENDING_SLOTS];
    logic [MEMBERS_PER_GROUP-1:0] slot_acks_reg [PENDING_SLOTS];
    logic [3:0]                   slot_rtr_reg  [PENDING_SLOTS];
    logic [15:0]                  slot_cd_reg   [PENDING_SLOTS];

    // Result hold and output stage
    logic        hold_valid_reg;
    logic [2:0]  hold_ev_reg;
    logic [15:0] hold_seq_reg;
    logic [15:0] hold_grp_reg;
    logic [47:0] hold_dest_reg;
    logic [3:0]  hold_lost_reg;
    logic [3:0]  hold_att_reg;
    logic        out_valid_reg;
    logic [2:0]  out_ev_reg;
    logic [15:0] out_seq_reg;
    logic [15:0] out_grp_reg;
    logic [47:0] out_dest_reg;
    logic [3:0]  out_lost_reg;
    logic [3:0]  out_att_reg;
    logic        out_last_reg;

    logic [MCW-1:0]               cur_mcnt;
    logic [MEMBERS_PER_GROUP-1:0] cur_acks;
    logic [15:0]                  cur_cd;
    logic                         all_ok;
    logic                         out_free;
    logic                         res_ok;
    logic                         push_new;
    logic                         push_out;
    logic [MCW-1:0]               jsel;
    logic [AW-1:0]                rd_addr;
    logic [AW-1:0]                wr_addr;
    logic                         mem_we;
    logic [47:0]                  wr_data;
    logic [15:0]                  e_seq;
    logic [15:0]                  e_grp;
    logic [47:0]                  e_dest;
    logic [3:0]                   e_lost;
    logic [3:0]                   e_att;

    assign cur_mcnt = mcnt_reg[g_reg];
    assign cur_acks = slot_acks_reg[si_reg];
    assign cur_cd   = slot_cd_reg[si_reg];
    assign out_free = !out_valid_reg || !out_stall;
    assign res_ok   = (res_cnt_reg < RCW'(mart_pkg::OUT_LIMIT));
    assign push_new = cmd.emit && res_ok;
    assign push_out = (push_new && hold_valid_reg) || cmd.flush;

    // Every member below the snapshot count has acknowledged
    always_comb
    begin
        all_ok = 1'b1;
        for (int b = 0; b < MEMBERS_PER_GROUP; b++)
        begin
            if (MCW'(b) < cnt_reg && !cur_acks[b])
                all_ok = 1'b0;
        end
    end

    // Status to controller
    always_comb
    begin
        sts             = '0;
        sts.kind        = kind_reg;
        sts.gi_lt_gu    = (gi_reg < gu_reg);
        sts.g_match     = (grp_num_reg[gi_reg[GW-1:0]] == gid_reg);
        sts.gu_full     = (gu_reg == GCW'(GROUP_SLOTS));
        sts.mj_lt_cnt   = (mj_reg < cnt_reg);
        sts.mj_lt_lim   = (mj_reg < cnt_reg) && (mj_reg < cur_mcnt);
        sts.addr_match  = (rdata_reg == addr_reg);
        sts.cnt_full    = (cnt_reg == MCW'(MEMBERS_PER_GROUP));
        sts.si_last     = (si_reg == SW'(PENDING_SLOTS - 1));
        sts.slot_act    = slot_act_reg[si_reg];
        sts.seq_match   = (slot_seq_reg[si_reg] == aseq_reg);
        sts.all_acked   = all_ok;
        sts.cd_hits     = (cur_cd <= 16'd1);
        sts.retry_limit = (slot_rtr_reg[si_reg] >= maxr_reg);
        sts.ack_bit     = cur_acks[mj_reg[MW-1:0]];
        sts.emit_ok     = !hold_valid_reg || out_free;
        sts.hold_valid  = hold_valid_reg;
        sts.out_free    = out_free;
    end

    // Member RAM addressing
    always_comb
    begin
        jsel    = cmd.rd_last ? (cnt_reg - MCW'(1)) : mj_reg;
        rd_addr = AW'(int'(g_reg) * MEMBERS_PER_GROUP + int'(jsel));
        mem_we  = cmd.wr_join || cmd.wr_leave;
        if (cmd.wr_join)
        begin
            wr_addr = AW'(int'(g_reg) * MEMBERS_PER_GROUP + int'(cnt_reg));
            wr_data = addr_reg;
        end
        else
        begin
            wr_addr = AW'(int'(g_reg) * MEMBERS_PER_GROUP + int'(jm_reg));
            wr_data = rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            member_ram[wr_addr] <= wr_data;
        if (cmd.mem_rd || cmd.rd_last)
            rdata_reg <= member_ram[rd_addr];
    end

    // Result fields
    always_comb
    begin
        if (cmd.ev == mart_pkg::EV_SEND || cmd.ev == mart_pkg::EV_DROP)
            e_seq = s_reg;
        else if (cmd.ev == mart_pkg::EV_FULL)
            e_seq = 16'd0;
        else
            e_seq = slot_seq_reg[si_reg];
        if (cmd.ev == mart_pkg::EV_SEND || cmd.ev == mart_pkg::EV_DROP ||
            cmd.ev == mart_pkg::EV_FULL)
            e_grp = gid_reg;
        else
            e_grp = grp_num_reg[g_reg];
        if (cmd.ev == mart_pkg::EV_SEND || cmd.ev == mart_pkg::EV_RETX)
            e_dest = rdata_reg;
        else
            e_dest = 48'd0;
        if (cmd.ev != mart_pkg::EV_EXPIRE)
            e_lost = 4'd0;
        else if (lost_reg > LW'(15))
            e_lost = 4'd15;
        else
            e_lost = lost_reg[3:0];
        if (cmd.ev == mart_pkg::EV_RETX || cmd.ev == mart_pkg::EV_EXPIRE)
            e_att = slot_rtr_reg[si_reg];
        else
            e_att = 4'd0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tmo_reg        <= mart_pkg::TIMEOUT_RST;
            maxr_reg       <= mart_pkg::RETRIES_RST;
            gu_reg         <= '0;
            next_seq_reg   <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            res_cnt_reg    <= '0;
            for (int g = 0; g < GROUP_SLOTS; g++)
                mcnt_reg[g] <= '0;
            for (int p = 0; p < PENDING_SLOTS; p++)
                slot_act_reg[p] <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == mart_pkg::CFG_TIMEOUT)
                    tmo_reg <= cfg_data;
                else
                    maxr_reg <= cfg_data[3:0];
            end
            if (cmd.g_add)
            begin
                gu_reg                 <= gu_reg + GCW'(1);
                mcnt_reg[gu_reg[GW-1:0]] <= '0;
            end
            if (cmd.wr_join)
                mcnt_reg[g_reg] <= cnt_reg + MCW'(1);
            if (cmd.wr_leave)
                mcnt_reg[g_reg] <= cnt_reg - MCW'(1);
            if (cmd.seq_take)
                next_seq_reg <= next_seq_reg + 16'd1;
            if (cmd.slot_init)
                slot_act_reg[si_reg] <= 1'b1;
            if (cmd.slot_free)
                slot_act_reg[si_reg] <= 1'b0;
            if (cmd.ld_item)
                res_cnt_reg <= '0;
            else if (push_new)
                res_cnt_reg <= res_cnt_reg + RCW'(1);
            if (cmd.flush)
                hold_valid_reg <= 1'b0;
            else if (push_new)
                hold_valid_reg <= 1'b1;
            if (push_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Item, walk and slot payload
    always_ff @(posedge clk)
    begin
        if (cmd.ld_item)
        begin
            kind_reg <= kind;
            gid_reg  <= group_no;
            addr_reg <= sub_addr;
            aseq_reg <= ack_seq;
        end
        if (cmd.gi_clr)
            gi_reg <= '0;
        else if (cmd.gi_inc)
            gi_reg <= gi_reg + GCW'(1);
        if (cmd.g_take)
            g_reg <= gi_reg[GW-1:0];
        else if (cmd.g_add)
        begin
            g_reg                     <= gu_reg[GW-1:0];
            grp_num_reg[gu_reg[GW-1:0]] <= gid_reg;
        end
        else if (cmd.slot_load)
            g_reg <= slot_grp_reg[si_reg];
        if (cmd.grp_load)
            cnt_reg <= cur_mcnt;
        else if (cmd.slot_load)
            cnt_reg <= slot_mem_reg[si_reg];
        if (cmd.mj_clr)
            mj_reg <= '0;
        else if (cmd.mj_inc)
            mj_reg <= mj_reg + MCW'(1);
        if (cmd.rd_last)
            jm_reg <= mj_reg[MW-1:0];
        if (cmd.seq_take)
            s_reg <= next_seq_reg;
        if (cmd.si_clr)
            si_reg <= '0;
        else if (cmd.si_inc)
            si_reg <= si_reg + SW'(1);
        if (cmd.lost_clr)
            lost_reg <= '0;
        else if (cmd.lost_acc && !cur_acks[mj_reg[MW-1:0]])
            lost_reg <= lost_reg + LW'(1);

        // Slot fields
        if (cmd.slot_init)
        begin
            slot_seq_reg[si_reg]  <= s_reg;
            slot_grp_reg[si_reg]  <= g_reg;
            slot_mem_reg[si_reg]  <= cnt_reg;
            slot_acks_reg[si_reg] <= '0;
            slot_rtr_reg[si_reg]  <= 4'd0;
            slot_cd_reg[si_reg]   <= tmo_reg;
        end
        if (cmd.ack_set)
            slot_acks_reg[si_reg][mj_reg[MW-1:0]] <= 1'b1;
        if (cmd.retry_inc)
            slot_rtr_reg[si_reg] <= slot_rtr_reg[si_reg] + 4'd1;
        if (cmd.cd_reload)
            slot_cd_reg[si_reg] <= tmo_reg;
        else if (cmd.tick_dec)
            slot_cd_reg[si_reg] <= (cur_cd == 16'd0) ? 16'd0 : cur_cd - 16'd1;

        // Hold one result back so the final one can carry the last flag
        if (push_new)
        begin
            hold_ev_reg   <= cmd.ev;
            hold_seq_reg  <= e_seq;
            hold_grp_reg  <= e_grp;
            hold_dest_reg <= e_dest;
            hold_lost_reg <= e_lost;
            hold_att_reg  <= e_att;
        end
        if (push_out)
        begin
            out_ev_reg   <= hold_ev_reg;
            out_seq_reg  <= hold_seq_reg;
            out_grp_reg  <= hold_grp_reg;
            out_dest_reg <= hold_dest_reg;
            out_lost_reg <= hold_lost_reg;
            out_att_reg  <= hold_att_reg;
            out_last_reg <= cmd.flush;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_code = out_ev_reg;
    assign seq        = out_seq_reg;
    assign out_group  = out_grp_reg;
    assign dest_addr  = out_dest_reg;
    assign lost_count = out_lost_reg;
    assign attempt    = out_att_reg;
    assign last       = out_last_reg;

`ifndef SYNTH
    // A result is only produced when the hold stage can move on
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!hold_valid_reg || out_free))
        else $error("result produced with hold and output both busy");

    // Flush only moves a held result into a free output stage
    a_flush_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |-> (hold_valid_reg && out_free))
        else $error("flush without held result or free output");

    // Group table never grows past its size
    a_gu_bound: assert property (@(posedge clk) disable iff (!rst_n)
        gu_reg <= GCW'(GROUP_SLOTS))
        else $error("group count out of range");

    // Result count stays within the per-item limit
    a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= RCW'(mart_pkg::OUT_LIMIT))
        else $error("result count out of range");
`endif

endmodule
